FILE: hdl/olid_pkg.sv
// Shared types, codes and defaults of the ordered list unit.
package olid_pkg;

	localparam int LIST_CAPACITY_DEF = 64;
	localparam int VALUE_BITS_DEF    = 30;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 30;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// What the captured word asks for, once checked against the list.
	typedef enum logic [2:0] {
		K_INSERT,
		K_FULL,
		K_DEL_HEAD,
		K_DEL_MID,
		K_BAD
	} kind_t;

	// Source of the next list memory read address.
	typedef enum logic [1:0] {
		RD_HOLD,
		RD_FRONT,
		RD_LINK
	} rd_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    exec;
		rd_sel_t rd_sel;
		logic    k_clr;
		logic    k_inc;
		logic    grab_gone;
		logic    unlink_head;
		logic    unlink_mid;
		logic    emit_elem;
		logic    emit_empty;
	} olid_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  list_empty;
		logic  walk_hit;
		logic  at_last;
		logic  out_free;
	} olid_sts_t;

endpackage

FILE: hdl/olid_item_if.sv
// Input word channel of the ordered list unit.
interface olid_item_if
	import olid_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [VALUE_W-1:0] item_value;
	logic [POS_W-1:0]   delete_position;

	modport source (output valid, opcode, item_value, delete_position, input ready);
	modport sink   (input valid, opcode, item_value, delete_position, output ready);
endinterface

FILE: hdl/olid_result_if.sv
// Result word channel of the ordered list unit.
interface olid_result_if
	import olid_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                has_element;
	logic [VALUE_W-1:0]  element_value;
	logic                is_last;

	modport source (output valid, status, has_element, element_value, is_last, input ready);
	modport sink   (input valid, status, has_element, element_value, is_last, output ready);
endinterface

FILE: hdl/ordered_list_insert_delete_unit.sv
// Top level of the ordered list unit: controller plus datapath.
//
// The unit keeps an ordered list of up to LIST_CAPACITY values as a singly
// linked chain of slots in two single-port-write memories (values and next
// links) with registered read data. Each input word inserts at the front,
// inserts at the back, or deletes the element at a zero-based position;
// after every word the whole list goes out front to back, one result word per
// element with is_last on the final one, or one word with has_element low
// when the list is empty. Status is the same on every result word of a run:
// done, index invalid (delete at or beyond the length, or opcode 3), or list
// full (insert dropped). A new element takes the lowest-numbered free slot.
// An insert or rejected word is captured, applied and then emitted; a delete
// at a nonzero position p first walks the links up to its predecessor. The
// walk and the emission both follow one link per cycle, the emission only
// while the output register is free, which is what the registered memory
// read port allows.
// The next input word is taken only after the last result word of the
// current one has been loaded into the output register; that register lets
// the result side stall freely without losing or repeating words.
module ordered_list_insert_delete_unit
	import olid_pkg::*;
#(
	parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
	parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	olid_item_if.sink     items,
	olid_result_if.source results
);

	olid_cmd_t cmd;
	olid_sts_t sts;

	// Sequence each word through capture, update, walk and emission.
	olid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the list, its pointers and the output register.
	olid_datapath #(
		.LIST_CAPACITY (LIST_CAPACITY),
		.VALUE_BITS    (VALUE_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (items.opcode),
		.item_value      (items.item_value),
		.delete_position (items.delete_position),
		.out_valid       (results.valid),
		.out_ready       (results.ready),
		.status          (results.status),
		.has_element     (results.has_element),
		.element_value   (results.element_value),
		.is_last         (results.is_last)
	);

endmodule

FILE: hdl/olid_datapath.sv
// Datapath: list memories, pointers, free slot map, walk counter and output register.
module olid_datapath
	import olid_pkg::*;
#(
	parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
	parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  olid_cmd_t           cmd,
	output olid_sts_t           sts,
	input  logic [OP_W-1:0]     opcode,
	input  logic [VALUE_W-1:0]  item_value,
	input  logic [POS_W-1:0]    delete_position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                has_element,
	output logic [VALUE_W-1:0]  element_value,
	output logic                is_last
);

	localparam int SlotBits  = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam int CountBits = $clog2(LIST_CAPACITY + 1);
	localparam int StoreBits = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	logic [StoreBits-1:0] elem_mem [LIST_CAPACITY];
	logic [SlotBits-1:0]  link_mem [LIST_CAPACITY];

	logic [StoreBits-1:0] elem_rd_q;
	logic [SlotBits-1:0]  link_rd_q;
	logic [SlotBits-1:0]  cur_q;
	logic [SlotBits-1:0]  rd_addr;

	logic [SlotBits-1:0]      front_q;
	logic [SlotBits-1:0]      back_q;
	logic [CountBits-1:0]     count_q;
	logic [LIST_CAPACITY-1:0] free_q;
	logic [CountBits-1:0]     k_q;
	logic [SlotBits-1:0]      gone_q;
	logic [SlotBits-1:0]      prev_q;

	logic [OP_W-1:0]      op_q;
	logic [StoreBits-1:0] val_q;
	logic [POS_W-1:0]     pos_q;
	logic [STATUS_W-1:0]  status_q;

	logic                out_v_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_has_q;
	logic [VALUE_W-1:0]  out_elem_q;
	logic                out_last_q;

	logic [SlotBits-1:0] free_slot;
	logic                found;
	kind_t               kind;
	logic                do_insert;
	logic                link_we;
	logic [SlotBits-1:0] link_wa;
	logic [SlotBits-1:0] link_wd;

	// Lowest-numbered free slot.
	always_comb begin
		free_slot = '0;
		found     = 1'b0;
		for (int i = 0; i < LIST_CAPACITY; i++) begin
			if (free_q[i] && !found) begin
				free_slot = SlotBits'(i);
				found     = 1'b1;
			end
		end
	end

	always_comb begin
		if (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK) begin
			kind = (count_q == CountBits'(LIST_CAPACITY)) ? K_FULL : K_INSERT;
		end else if (op_q == OP_DELETE && pos_q < POS_W'(count_q)) begin
			kind = (pos_q == '0) ? K_DEL_HEAD : K_DEL_MID;
		end else begin
			kind = K_BAD;
		end
	end

	assign do_insert = cmd.exec && (kind == K_INSERT);

	always_comb begin
		sts.kind       = kind;
		sts.list_empty = (count_q == '0);
		sts.walk_hit   = (POS_W'(k_q) == pos_q - POS_W'(1));
		sts.at_last    = (k_q == count_q - CountBits'(1));
		sts.out_free   = !out_v_q || out_ready;
	end

	// Single link write port: splice on insert, bypass on a middle delete.
	always_comb begin
		link_we = 1'b0;
		link_wa = free_slot;
		link_wd = front_q;
		if (do_insert && count_q != '0) begin
			link_we = 1'b1;
			if (op_q == OP_PUSH_BACK) begin
				link_wa = back_q;
				link_wd = free_slot;
			end
		end else if (cmd.unlink_mid) begin
			link_we = 1'b1;
			link_wa = prev_q;
			link_wd = link_rd_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FRONT: rd_addr = front_q;
			RD_LINK:  rd_addr = link_rd_q;
			default:  rd_addr = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			elem_mem[free_slot] <= val_q;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		elem_rd_q <= elem_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			free_q  <= '1;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (do_insert) begin
				free_q[free_slot] <= 1'b0;
				count_q           <= count_q + CountBits'(1);
				if (count_q == '0) begin
					front_q <= free_slot;
					back_q  <= free_slot;
				end else if (op_q == OP_PUSH_BACK) begin
					back_q <= free_slot;
				end else begin
					front_q <= free_slot;
				end
			end
			if (cmd.unlink_head) begin
				free_q[front_q] <= 1'b1;
				count_q         <= count_q - CountBits'(1);
				if (count_q == CountBits'(1)) begin
					front_q <= '0;
					back_q  <= '0;
				end else begin
					front_q <= link_rd_q;
				end
			end
			if (cmd.unlink_mid) begin
				free_q[gone_q] <= 1'b1;
				count_q        <= count_q - CountBits'(1);
				if (gone_q == back_q) begin
					back_q <= prev_q;
				end
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + CountBits'(1);
			end
			if (cmd.emit_elem || cmd.emit_empty) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= rd_addr;
		if (cmd.load_in) begin
			op_q  <= opcode;
			val_q <= item_value[StoreBits-1:0];
			pos_q <= delete_position;
		end
		if (cmd.exec) begin
			unique case (kind)
				K_FULL:  status_q <= ST_FULL;
				K_BAD:   status_q <= ST_BAD_INDEX;
				default: status_q <= ST_DONE;
			endcase
		end
		if (cmd.grab_gone) begin
			gone_q <= link_rd_q;
			prev_q <= cur_q;
		end
		if (cmd.emit_elem) begin
			out_status_q <= status_q;
			out_has_q    <= 1'b1;
			out_elem_q   <= VALUE_W'(elem_rd_q);
			out_last_q   <= sts.at_last;
		end else if (cmd.emit_empty) begin
			out_status_q <= status_q;
			out_has_q    <= 1'b0;
			out_elem_q   <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_v_q;
	assign status        = out_status_q;
	assign has_element   = out_has_q;
	assign element_value = out_elem_q;
	assign is_last       = out_last_q;

endmodule

FILE: hdl/olid_ctrl.sv
// Controller: sequences capture, list update, delete walk and emission.
module olid_ctrl
	import olid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  olid_sts_t sts,
	output olid_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEL_HEAD,
		S_WALK,
		S_DEL_MID,
		S_START,
		S_EMIT,
		S_EMPTY
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_HOLD;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				unique case (sts.kind)
					K_DEL_HEAD: begin
						cmd.rd_sel = RD_FRONT;
						state_d    = S_DEL_HEAD;
					end
					K_DEL_MID: begin
						cmd.rd_sel = RD_FRONT;
						cmd.k_clr  = 1'b1;
						state_d    = S_WALK;
					end
					default: state_d = S_START;
				endcase
			end
			S_DEL_HEAD: begin
				cmd.unlink_head = 1'b1;
				state_d         = S_START;
			end
			S_WALK: begin
				// advance one link a cycle until the predecessor is reached
				cmd.rd_sel = RD_LINK;
				if (sts.walk_hit) begin
					cmd.grab_gone = 1'b1;
					state_d       = S_DEL_MID;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			S_DEL_MID: begin
				cmd.unlink_mid = 1'b1;
				state_d        = S_START;
			end
			S_START: begin
				cmd.rd_sel = RD_FRONT;
				cmd.k_clr  = 1'b1;
				state_d    = sts.list_empty ? S_EMPTY : S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_elem = 1'b1;
					if (sts.at_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_sel = RD_LINK;
						cmd.k_inc  = 1'b1;
					end
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
